// File: rtl/core/huffman_code_bit_packer_unit_defines.svh
// Assertion macros for the Huffman bit packer checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define HCBP_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define HCBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/core/hcbp_pkg.sv
// Shared types and constants of the Huffman bit packer.
// No dependencies; imported by the interfaces, front end, queue, packer and top level.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_NUM_SYMBOLS  = 256;

    localparam int ACTION_BITS    = 2;
    localparam int SYM_BITS       = 8;
    localparam int CODE_WORD_BITS = 32;
    localparam int LEN_FIELD_BITS = 6;
    localparam int BYTE_BITS      = 8;
    localparam int PEND_BITS      = BYTE_BITS - 1;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    // Work handed from the front end to the packer
    typedef enum logic [1:0] {
        OP_ENC   = 2'd0,
        OP_ERR   = 2'd1,
        OP_FLUSH = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t                    kind;
        logic [CODE_WORD_BITS-1:0]   code;
        logic [LEN_FIELD_BITS-1:0]   len;
    } op_t;

endpackage

// File: rtl/core/hcbp_item_if.sv
// Input channel of the Huffman bit packer: valid/ready plus one item word.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

interface hcbp_item_if;
    import hcbp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACTION_BITS-1:0]    action;
    logic [SYM_BITS-1:0]       symbol;
    logic [CODE_WORD_BITS-1:0] code_bits;
    logic [LEN_FIELD_BITS-1:0] code_length;

    modport source (output valid, action, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

// File: rtl/core/hcbp_result_if.sv
// Result channel of the Huffman bit packer: valid/ready plus one result word.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

interface hcbp_result_if;
    import hcbp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 is_error;
    logic                 last_in_run;

    modport source (output valid, out_byte, is_error, last_in_run, input ready);
    modport sink   (input valid, out_byte, is_error, last_in_run, output ready);
endinterface

// File: rtl/core/hcbp_front.sv
// Front end: accepts words, owns the code table and its valid bits,
// classifies each encode/flush into a packer op. Depends on hcbp_pkg, hcbp_item_if.
`timescale 1ns / 1ps

module hcbp_front #(
    parameter int CODE_W      = hcbp_pkg::CODE_WORD_BITS,
    parameter int NUM_SYMBOLS = hcbp_pkg::DEF_NUM_SYMBOLS
) (
    input  logic         clk,
    input  logic         rst_n,
    hcbp_item_if.sink    item,
    input  logic         q_ready,
    output logic         push,
    output hcbp_pkg::op_t push_op
);
    import hcbp_pkg::*;

    localparam int SYM_W = $clog2(NUM_SYMBOLS);
    localparam int LEN_W = $clog2(CODE_W + 1);
    localparam int ENT_W = CODE_W + LEN_W;
    localparam logic [SYM_BITS:0]       SYM_LIMIT = (SYM_BITS + 1)'(NUM_SYMBOLS);
    localparam logic [LEN_FIELD_BITS-1:0] LEN_CAP = LEN_FIELD_BITS'(CODE_W);

    // Code table: {length, code} per symbol, undefined until loaded
    logic [ENT_W-1:0]       mem [NUM_SYMBOLS];
    logic [ENT_W-1:0]       rd_reg;
    logic [NUM_SYMBOLS-1:0] vbit_reg, vbit_next;

    logic                 s1_valid_reg, s1_valid_next;
    op_kind_t             s1_kind_reg, s1_kind_next;

    logic                      accept;
    logic [SYM_W-1:0]          idx;
    logic                      in_range;
    logic                      hit;
    logic                      wr_en;
    logic [LEN_FIELD_BITS-1:0] len_sat;
    logic [CODE_W-1:0]         code_mask;
    logic [ENT_W-1:0]          wr_data;
    logic                      enq;
    op_kind_t                  kind;

    assign accept   = item.valid && item.ready;
    assign idx      = item.symbol[SYM_W-1:0];
    assign in_range = {1'b0, item.symbol} < SYM_LIMIT;
    assign hit      = in_range && vbit_reg[idx];

    // Long codes saturate; bits above the stored length are dropped
    assign len_sat   = (item.code_length > LEN_CAP) ? LEN_CAP : item.code_length;
    assign code_mask = ~({CODE_W{1'b1}} << len_sat);
    assign wr_data   = {len_sat[LEN_W-1:0], item.code_bits[CODE_W-1:0] & code_mask};
    assign wr_en     = accept && (item.action == ACT_LOAD) && in_range;

    always_comb
    begin
        unique case (item.action)
            ACT_ENCODE:
            begin
                enq  = 1'b1;
                kind = hit ? OP_ENC : OP_ERR;
            end
            ACT_FLUSH:
            begin
                enq  = 1'b1;
                kind = OP_FLUSH;
            end
            default:
            begin
                enq  = 1'b0;
                kind = OP_FLUSH;
            end
        endcase
    end

    assign item.ready = !s1_valid_reg || q_ready;
    assign push       = s1_valid_reg && q_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_kind_next  = s1_kind_reg;
        vbit_next     = vbit_reg;
        if (accept)
        begin
            s1_valid_next = enq;
            s1_kind_next  = kind;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
        if (wr_en)
        begin
            vbit_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= OP_FLUSH;
            vbit_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_kind_reg  <= s1_kind_next;
            vbit_reg     <= vbit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx] <= wr_data;
        end
        if (accept)
        begin
            rd_reg <= mem[idx];
        end
    end

    assign push_op.kind = s1_kind_reg;
    assign push_op.code = CODE_WORD_BITS'(rd_reg[CODE_W-1:0]);
    assign push_op.len  = LEN_FIELD_BITS'(rd_reg[ENT_W-1:CODE_W]);

endmodule

// File: rtl/core/hcbp_queue.sv
// Short FIFO of packer ops between front end and packer.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hcbp_pkg::op_t push_op,
    output logic          ready,
    output logic          head_valid,
    output hcbp_pkg::op_t head_op,
    input  logic          pop
);
    import hcbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] FULL = (PTR_W + 1)'(QUEUE_DEPTH);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign ready      = count_reg != FULL;
    assign head_valid = count_reg != '0;
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: rtl/core/hcbp_back.sv
// Packer: merges codes into the bit accumulator, emits one byte per cycle, while
// the output register is free, into that register. Depends on hcbp_pkg, hcbp_result_if.
`timescale 1ns / 1ps

module hcbp_back #(
    parameter int CODE_W = hcbp_pkg::CODE_WORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  hcbp_pkg::op_t head_op,
    output logic          pop,
    hcbp_result_if.source result
);
    import hcbp_pkg::*;

    localparam int ACC_W = CODE_W + PEND_BITS;
    localparam int TOT_W = $clog2(CODE_W + BYTE_BITS);
    localparam int PAD_W = BYTE_BITS + PEND_BITS;
    localparam logic [TOT_W-1:0] TOT_BYTE = TOT_W'(BYTE_BITS);

    // Unemitted bits sit in the low total_reg bits of acc_reg
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0] out_byte_reg, out_byte_next;
    logic                 out_err_reg, out_err_next;
    logic                 out_last_reg, out_last_next;

    logic                 emit_need;
    logic [TOT_W-1:0]     tot_m8;
    logic                 out_free;
    logic                 can_emit;
    logic                 last_emit;
    logic                 settle;
    logic [2:0]           rem;
    logic [PEND_BITS-1:0] pend;
    logic [ACC_W-1:0]     merged;
    logic [ACC_W-1:0]     acc_shift;
    logic [PAD_W-1:0]     pad_wide;
    logic                 load_out;

    assign emit_need = total_reg >= TOT_BYTE;
    assign tot_m8    = total_reg - TOT_BYTE;
    assign out_free  = !out_valid_reg || result.ready;
    assign can_emit  = emit_need && out_free;
    assign last_emit = tot_m8 < TOT_BYTE;
    // Fewer than a byte left after this cycle: a new op may merge in
    assign settle    = !emit_need || (can_emit && last_emit);
    assign rem       = emit_need ? tot_m8[2:0] : total_reg[2:0];

    assign pend      = acc_reg[PEND_BITS-1:0] & ~({PEND_BITS{1'b1}} << rem);
    assign merged    = ({{CODE_W{1'b0}}, pend} << head_op.len)
                       | {{PEND_BITS{1'b0}}, head_op.code[CODE_W-1:0]};
    assign acc_shift = acc_reg >> tot_m8;
    assign pad_wide  = {{BYTE_BITS{1'b0}}, pend} << (4'(BYTE_BITS) - {1'b0, rem});

    always_comb
    begin
        acc_next      = acc_reg;
        total_next    = total_reg;
        pop           = 1'b0;
        load_out      = 1'b0;
        out_byte_next = out_byte_reg;
        out_err_next  = out_err_reg;
        out_last_next = out_last_reg;

        if (can_emit)
        begin
            total_next    = tot_m8;
            load_out      = 1'b1;
            out_byte_next = acc_shift[BYTE_BITS-1:0];
            out_err_next  = 1'b0;
            out_last_next = last_emit;
        end

        if (head_valid)
        begin
            unique case (head_op.kind)
                OP_ENC:
                begin
                    if (settle)
                    begin
                        pop        = 1'b1;
                        acc_next   = merged;
                        total_next = TOT_W'(rem) + TOT_W'(head_op.len);
                    end
                end
                OP_ERR:
                begin
                    if (!emit_need && out_free)
                    begin
                        pop           = 1'b1;
                        load_out      = 1'b1;
                        out_byte_next = '0;
                        out_err_next  = 1'b1;
                        out_last_next = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    if (rem == 3'd0)
                    begin
                        if (settle)
                        begin
                            pop        = 1'b1;
                            total_next = '0;
                        end
                    end
                    else if (!emit_need && out_free)
                    begin
                        pop           = 1'b1;
                        total_next    = '0;
                        load_out      = 1'b1;
                        out_byte_next = pad_wide[BYTE_BITS-1:0];
                        out_err_next  = 1'b0;
                        out_last_next = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b0;
                end
            endcase
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.is_error    = out_err_reg;
    assign result.last_in_run = out_last_reg;

endmodule

// File: rtl/core/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer (MSB-first).
// Depends on hcbp_pkg, hcbp_item_if, hcbp_result_if, hcbp_front, hcbp_queue, hcbp_back.
//
// Usage:
//   item   - input words: load a table entry (symbol, code_bits, code_length),
//            encode a symbol, or flush the partial byte. Taken on valid && ready.
//   result - output words: a packed byte (first code bit in bit 7), or an error
//            word for a symbol without a loaded code; last_in_run marks the
//            final word caused by one input word.
// Path: an error or flush word passes the front-end stage, op queue and output
//   register; an encode's first byte also the bit accumulator; loads give no word.
// Throughput: one input word per cycle while each encode yields at most one
//   byte and result.ready is high; an error or flush word right behind an emitted
//   byte waits until under a byte is pending. A code that completes more than one
//   byte holds the packer: one byte per cycle goes to the single output register.
// Stall: when result.ready is low, the output register holds its word; the
//   packer stops, the two-entry op queue fills, then item.ready drops.
// Reset: pipeline, queue and pending bits are cleared and all table entries
//   are marked not loaded; the table contents are undefined until loaded.
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = hcbp_pkg::DEF_NUM_SYMBOLS
) (
    input  logic          clk,
    input  logic          rst_n,
    hcbp_item_if.sink     item,
    hcbp_result_if.source result
);
    import hcbp_pkg::*;

    // Stored code width: saturated to the code_bits field width
    localparam int CODE_W = (MAX_CODE_LEN < CODE_WORD_BITS) ? MAX_CODE_LEN : CODE_WORD_BITS;

    logic q_ready;
    logic push;
    op_t  push_op;
    logic head_valid;
    op_t  head_op;
    logic pop;

    // Front end: table lookup/load and op classification
    hcbp_front #(
        .CODE_W      (CODE_W),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_ready (q_ready),
        .push    (push),
        .push_op (push_op)
    );

    // Decouples table lookup from byte emission
    hcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .ready      (q_ready),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop)
    );

    // Bit accumulator and output register
    hcbp_back #(
        .CODE_W (CODE_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: rtl/core/hcbp_checker.sv
// Port-level assertions for the Huffman bit packer, bound to the top level.
// Depends on huffman_code_bit_packer_unit_defines.svh and the top level.
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_unit_defines.svh"

module hcbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_error,
    input logic       last_in_run
);

    `HCBP_ASSERT_ALWAYS(a_no_word_in_reset, !rst_n |-> (out_valid !== 1'b1), "result word during reset")

    `HCBP_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")

    `HCBP_ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_byte) && $stable(is_error) && $stable(last_in_run), "stalled word changed")

    `HCBP_ASSERT_CLK(a_err_form, out_valid && is_error |-> last_in_run && (out_byte == 8'd0), "malformed error word")

    `HCBP_ASSERT_CLK(a_in_hold, in_valid && !in_ready |=> in_valid, "input word withdrawn")

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_byte    (result.out_byte),
    .is_error    (result.is_error),
    .last_in_run (result.last_in_run)
);
